/* sv/arx_block_cipher_128_defines.svh */
// assertion macros shared by the cipher rtl
// no dependencies; included by the files that carry assertions
`ifndef ARX_BLOCK_CIPHER_128_DEFINES_SVH
`define ARX_BLOCK_CIPHER_128_DEFINES_SVH

`ifndef SYNTH
`define ARXBC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("arxbc assertion failed");
`define ARXBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("arxbc assertion failed");
`else
`define ARXBC_ASSERT_SAME(lbl, ante, cons)
`define ARXBC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* sv/arxbc_pkg.sv */
// types, constants and rotate helpers for the arx block cipher
// no dependencies; used by every module of the block
package arxbc_pkg;

    localparam int WORD_W    = 64;
    localparam int CFG_IDX_W = 2;

    typedef logic [WORD_W-1:0] t_word;

    localparam logic [5:0] ROT_X   = 6'd3;
    localparam logic [5:0] ROT_Y   = 6'd5;
    localparam logic [5:0] ROT_MIX = 6'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONST_P    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONST_Q    = 2'd3;

    localparam logic KIND_ENC = 1'b0;
    localparam logic KIND_DEC = 1'b1;

    typedef struct packed {
        logic  valid;
        logic  kind;
        t_word x;
        t_word y;
    } t_cell;

    function automatic t_word rot_l(input t_word x, input logic [5:0] r);
        logic [6:0] back;
        back = 7'd64 - {1'b0, r};
        return (x << r) | (x >> back);
    endfunction

    function automatic t_word rot_r(input t_word x, input logic [5:0] r);
        logic [6:0] back;
        back = 7'd64 - {1'b0, r};
        return (x >> r) | (x << back);
    endfunction

endpackage

/* sv/arx_block_cipher_128.sv */
// top level of the 128-bit arx block cipher: cell chain, key sequencer, output skid
// depends on arxbc_pkg, arxbc_key_sched, arxbc_round_cell and the defines header
`include "arx_block_cipher_128_defines.svh"

// One block enters per clock while the input is ready. The first round cell captures
// the block at the accepting edge, each further cell registers it in turn and the
// output register follows the last cell. While a result waits the chain takes one
// more step into a skid register, then the chain and the input stall until the
// result is taken. After reset and after every configuration register write the
// round keys are derived again by a sequencer that passes through a mix and a key
// state for each of the 2*NUM_ROUNDS round keys after one load state, and no block
// is taken until it is done.
module arx_block_cipher_128 #(
    parameter int NUM_ROUNDS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [arxbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_kind,
    input  logic [63:0]                     i_half_in_first,
    input  logic [63:0]                     i_half_in_second,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [63:0]                     o_half_out_first,
    output logic [63:0]                     o_half_out_second
);

    arxbc_pkg::t_word w_rk [2*NUM_ROUNDS];
    arxbc_pkg::t_cell w_chain [NUM_ROUNDS+1];
    logic             w_keys_ok;
    logic             w_en;
    logic             r_out_v, r_skid_v;
    arxbc_pkg::t_word r_out_x, r_out_y, r_skid_x, r_skid_y;

    arxbc_key_sched #(
        .NUM_ROUNDS (NUM_ROUNDS)
    ) u_key_sched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_keys_ok   (w_keys_ok),
        .o_rk        (w_rk)
    );

    assign w_en       = !r_skid_v;
    assign o_in_ready = w_keys_ok && !r_skid_v;

    assign w_chain[0] = '{valid: i_in_valid && o_in_ready, kind: i_kind,
                          x: i_half_in_first, y: i_half_in_second};

    for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_cell
        arxbc_round_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_enc_k0 (w_rk[2*i]),
            .i_enc_k1 (w_rk[2*i+1]),
            .i_dec_k0 (w_rk[2*(NUM_ROUNDS-1-i)]),
            .i_dec_k1 (w_rk[2*(NUM_ROUNDS-1-i)+1]),
            .i_cell   (w_chain[i]),
            .o_cell   (w_chain[i+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_out_ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= w_chain[NUM_ROUNDS].valid;
            end
        end else if (w_en && w_chain[NUM_ROUNDS].valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_out_ready) begin
            if (r_skid_v) begin
                r_out_x <= r_skid_x;
                r_out_y <= r_skid_y;
            end else begin
                r_out_x <= w_chain[NUM_ROUNDS].x;
                r_out_y <= w_chain[NUM_ROUNDS].y;
            end
        end else if (w_en) begin
            r_skid_x <= w_chain[NUM_ROUNDS].x;
            r_skid_y <= w_chain[NUM_ROUNDS].y;
        end
    end

    assign o_out_valid       = r_out_v;
    assign o_half_out_first  = r_out_x;
    assign o_half_out_second = r_out_y;

    `ARXBC_ASSERT_SAME(a_skid_behind_out, r_skid_v, r_out_v)
    `ARXBC_ASSERT_NEXT(a_cfg_blocks_input, i_cfg_we, !o_in_ready)
    `ARXBC_ASSERT_NEXT(a_skid_fill_only_stalled,
        !r_skid_v && !(r_out_v && !i_out_ready), !r_skid_v)

endmodule

/* sv/arxbc_key_sched.sv */
// configuration registers and round key sequencer with its key store
// depends on arxbc_pkg and arx_block_cipher_128_defines.svh
`include "arx_block_cipher_128_defines.svh"

module arxbc_key_sched #(
    parameter int NUM_ROUNDS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [arxbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  arxbc_pkg::t_word                i_cfg_data,
    output logic                            o_keys_ok,
    output arxbc_pkg::t_word                o_rk [2*NUM_ROUNDS]
);

    localparam int NUM_KEYS = 2 * NUM_ROUNDS;
    localparam int STEP_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_KEYS - 1);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_MIX  = 2'd1;
    localparam logic [1:0] ST_KEY  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    arxbc_pkg::t_word r_key_first, r_key_second, r_const_p, r_const_q;
    arxbc_pkg::t_word r_a, r_b, r_mix_rot;
    arxbc_pkg::t_word n_b;
    arxbc_pkg::t_word w_b_add;
    logic [1:0]        r_state;
    logic [STEP_W-1:0] r_step;
    arxbc_pkg::t_word  r_rk [NUM_KEYS];

    assign w_b_add = arxbc_pkg::rot_l(r_b, arxbc_pkg::ROT_Y) + r_const_q;
    assign n_b     = (arxbc_pkg::rot_r(r_b, arxbc_pkg::ROT_X) + r_a) ^ r_mix_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_first  <= '0;
            r_key_second <= '0;
            r_const_p    <= '0;
            r_const_q    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                arxbc_pkg::CFG_KEY_FIRST:  r_key_first  <= i_cfg_data;
                arxbc_pkg::CFG_KEY_SECOND: r_key_second <= i_cfg_data;
                arxbc_pkg::CFG_CONST_P:    r_const_p    <= i_cfg_data;
                arxbc_pkg::CFG_CONST_Q:    r_const_q    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_step  <= '0;
        end else if (i_cfg_we) begin
            r_state <= ST_LOAD;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                ST_LOAD: r_state <= ST_MIX;
                ST_MIX:  r_state <= ST_KEY;
                ST_KEY: begin
                    r_step  <= r_step + 1'b1;
                    r_state <= (r_step == STEP_LAST) ? ST_DONE : ST_MIX;
                end
                ST_DONE: r_state <= ST_DONE;
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_LOAD: begin
                r_a       <= r_key_first;
                r_b       <= r_key_second;
                r_mix_rot <= r_const_p ^ r_const_q;
            end
            ST_MIX: begin
                r_a <= (arxbc_pkg::rot_r(r_a, arxbc_pkg::ROT_X) + r_const_p) ^ w_b_add;
                r_b <= w_b_add;
            end
            ST_KEY: begin
                r_b           <= n_b;
                r_rk[r_step]  <= n_b;
                r_mix_rot     <= arxbc_pkg::rot_l(r_mix_rot, arxbc_pkg::ROT_MIX);
            end
            default: ;
        endcase
    end

    assign o_keys_ok = (r_state == ST_DONE);

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_rk
        assign o_rk[k] = r_rk[k];
    end

    `ARXBC_ASSERT_NEXT(a_cfg_restarts, i_cfg_we, r_state == ST_LOAD && r_step == '0)
    `ARXBC_ASSERT_NEXT(a_last_key_done,
        !i_cfg_we && r_state == ST_KEY && r_step == STEP_LAST, o_keys_ok)
    `ARXBC_ASSERT_NEXT(a_done_holds, !i_cfg_we && o_keys_ok, o_keys_ok)

endmodule

/* sv/arxbc_round_cell.sv */
// one round cell of the cipher chain, encrypt or inverse round per beat
// depends on arxbc_pkg
module arxbc_round_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  arxbc_pkg::t_word i_enc_k0,
    input  arxbc_pkg::t_word i_enc_k1,
    input  arxbc_pkg::t_word i_dec_k0,
    input  arxbc_pkg::t_word i_dec_k1,
    input  arxbc_pkg::t_cell i_cell,
    output arxbc_pkg::t_cell o_cell
);

    arxbc_pkg::t_cell r_cell;
    arxbc_pkg::t_word w_enc_x, w_enc_y, w_dec_x, w_dec_y;

    assign w_enc_x = arxbc_pkg::rot_r(i_cell.x ^ i_cell.y, arxbc_pkg::ROT_X) ^ i_enc_k0;
    assign w_enc_y = arxbc_pkg::rot_l(i_cell.y ^ w_enc_x, arxbc_pkg::ROT_Y) ^ i_enc_k1;
    assign w_dec_y = arxbc_pkg::rot_r(i_cell.y ^ i_dec_k1, arxbc_pkg::ROT_Y) ^ i_cell.x;
    assign w_dec_x = arxbc_pkg::rot_l(i_cell.x ^ i_dec_k0, arxbc_pkg::ROT_X) ^ w_dec_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= i_cell.valid;
            r_cell.kind  <= i_cell.kind;
            if (i_cell.kind == arxbc_pkg::KIND_DEC) begin
                r_cell.x <= w_dec_x;
                r_cell.y <= w_dec_y;
            end else begin
                r_cell.x <= w_enc_x;
                r_cell.y <= w_enc_y;
            end
        end
    end

    assign o_cell = r_cell;

endmodule
